// File: hdl/cfws_pkg.sv
`default_nettype none

package cfws_pkg;

  // fixed field widths of the item channels
  localparam int unsigned KindWidth   = 2;
  localparam int unsigned WordWidth   = 32;
  localparam int unsigned PosWidth    = 10;
  localparam int unsigned OccWidth    = 11;
  localparam int unsigned StatusWidth = 2;

  // operation codes
  typedef enum logic [KindWidth-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  // result status codes
  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP_RD,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [WordWidth-1:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic [WordWidth-1:0]   popped_word;
    logic [StatusWidth-1:0] status;
    logic                   match_found;
    logic [PosWidth-1:0]    match_position;
    logic                   is_empty;
    logic [OccWidth-1:0]    occupancy;
    logic [WordWidth-1:0]   front_word;
    logic [WordWidth-1:0]   rear_word;
  } out_item_t;

endpackage

`default_nettype wire

// File: hdl/cfws_ram.sv
`default_nettype none

module cfws_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     wr_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                         wr_data_i,
  input  wire logic                                     rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // one registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/cfws_ctrl.sv
`default_nettype none

module cfws_ctrl #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire cfws_pkg::in_item_t   in_item_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output cfws_pkg::out_item_t       res_item_o
);

  import cfws_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  state_e                state_q, state_d;
  logic [KindWidth-1:0]  op_q, op_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic [AW-1:0]         front_ptr_q, front_ptr_d;
  logic [AW-1:0]         rear_ptr_q, rear_ptr_d;
  logic [CW-1:0]         count_q, count_d;
  logic [DATA_WIDTH-1:0] front_word_q, front_word_d;
  logic [DATA_WIDTH-1:0] rear_word_q, rear_word_d;
  logic [DATA_WIDTH-1:0] popped_q, popped_d;
  status_e               status_q, status_d;
  logic                  found_q, found_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [AW-1:0]         scan_addr_q, scan_addr_d;
  logic                  rd_vld_q, rd_vld_d;

  logic                  wr_en;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  hit;
  logic                  is_full;
  logic                  is_empty;
  logic                  scan_last;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == LastPtr) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [WordWidth-1:0] to_word(input logic [DATA_WIDTH-1:0] w);
    logic [63:0] ext;
    ext = 64'(w);
    return ext[WordWidth-1:0];
  endfunction

  // entry store
  cfws_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (rear_ptr_q),
    .wr_data_i (key_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // search compare unit and status flags
  assign hit       = rd_vld_q && (rd_data == key_q);
  assign is_full   = (count_q == FullCnt);
  assign is_empty  = (count_q == '0);
  assign scan_last = (pos_q == count_q - CW'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op_q)
          KIND_POP: begin
            state_d = (count_q > CW'(1)) ? ST_POP_RD : ST_DONE;
          end
          KIND_SEARCH: begin
            state_d = is_empty ? ST_DONE : ST_SCAN;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_POP_RD: begin
        state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (rd_vld_q && (hit || scan_last)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE);
    wr_en       = (state_q == ST_EXEC) && (op_q == KIND_PUSH) && !is_full;
    rd_en       = ((state_q == ST_EXEC) && (op_q == KIND_POP) && (count_q > CW'(1)))
                  || (state_q == ST_SCAN);
    rd_addr     = (state_q == ST_SCAN) ? scan_addr_q : next_ptr(front_ptr_q);
  end

  // queue and search datapath
  always_comb begin
    logic [63:0] key_ext;
    key_ext      = 64'(in_item_i.data_word);
    op_d         = op_q;
    key_d        = key_q;
    front_ptr_d  = front_ptr_q;
    rear_ptr_d   = rear_ptr_q;
    count_d      = count_q;
    front_word_d = front_word_q;
    rear_word_d  = rear_word_q;
    popped_d     = popped_q;
    status_d     = status_q;
    found_d      = found_q;
    pos_d        = pos_q;
    scan_addr_d  = scan_addr_q;
    rd_vld_d     = (state_q == ST_SCAN);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_item_i.kind;
          key_d    = key_ext[DATA_WIDTH-1:0];
          popped_d = '0;
          status_d = STATUS_OK;
          found_d  = 1'b0;
          pos_d    = '0;
        end
      end
      ST_EXEC: begin
        unique case (op_q)
          KIND_PUSH: begin
            if (is_full) begin
              status_d = STATUS_FULL;
            end else begin
              rear_ptr_d  = next_ptr(rear_ptr_q);
              count_d     = count_q + CW'(1);
              rear_word_d = key_q;
              if (is_empty) begin
                front_word_d = key_q;
              end
            end
          end
          KIND_POP: begin
            if (is_empty) begin
              status_d = STATUS_EMPTY;
            end else begin
              popped_d    = front_word_q;
              front_ptr_d = next_ptr(front_ptr_q);
              count_d     = count_q - CW'(1);
            end
          end
          KIND_SEARCH: begin
            if (is_empty) begin
              status_d = STATUS_EMPTY;
            end else begin
              scan_addr_d = front_ptr_q;
            end
          end
          default: begin
            status_d = STATUS_OK;
          end
        endcase
      end
      ST_POP_RD: begin
        front_word_d = rd_data;
      end
      ST_SCAN: begin
        scan_addr_d = next_ptr(scan_addr_q);
        if (rd_vld_q) begin
          if (hit) begin
            found_d = 1'b1;
          end else begin
            pos_d = pos_q + CW'(1);
          end
        end
      end
      default: begin
        rd_vld_d = 1'b0;
      end
    endcase
  end

  // result assembly from the post-step state
  always_comb begin
    logic [63:0] pos_ext;
    logic [63:0] occ_ext;
    pos_ext                       = 64'(pos_q);
    occ_ext                       = 64'(count_q);
    res_item_o.popped_word        = to_word(popped_q);
    res_item_o.status             = status_q;
    res_item_o.match_found        = found_q;
    res_item_o.match_position     = found_q ? pos_ext[PosWidth-1:0] : '0;
    res_item_o.is_empty           = is_empty;
    res_item_o.occupancy          = occ_ext[OccWidth-1:0];
    res_item_o.front_word         = is_empty ? '0 : to_word(front_word_q);
    res_item_o.rear_word          = is_empty ? '0 : to_word(rear_word_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_ptr_q <= '0;
      rear_ptr_q  <= '0;
      count_q     <= '0;
      status_q    <= STATUS_OK;
      found_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      op_q        <= '0;
    end else begin
      state_q     <= state_d;
      front_ptr_q <= front_ptr_d;
      rear_ptr_q  <= rear_ptr_d;
      count_q     <= count_d;
      status_q    <= status_d;
      found_q     <= found_d;
      rd_vld_q    <= rd_vld_d;
      op_q        <= op_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    front_word_q <= front_word_d;
    rear_word_q  <= rear_word_d;
    popped_q     <= popped_d;
    pos_q        <= pos_d;
    scan_addr_q  <= scan_addr_d;
  end

endmodule

`default_nettype wire

// File: hdl/circular_fifo_with_search.sv
// channel   direction   payload                    handshake
// in        input       cfws_pkg::in_item_t         in_valid_i / in_ready_o
// out       output      cfws_pkg::out_item_t        out_valid_o / out_ready_i
//
// push, unused codes, pop or search of an empty queue, pop of last entry: EXEC, DONE
// any other pop: EXEC, POP_RD, DONE; POP_RD reloads the front word from the store
// search: EXEC, then SCAN with one entry compared per cycle through the
// single read port of the entry store, ending early at the first match
// reset clears control registers only; store contents are never read unwritten
// a finished result waits in the output register while the next item is taken

`default_nettype none

module circular_fifo_with_search #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire cfws_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output cfws_pkg::out_item_t       out_item_o
);

  import cfws_pkg::*;

  logic      res_valid;
  logic      res_ready;
  out_item_t res_item;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  // sequencer, pointers and search unit
  cfws_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_item_d  = res_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// File: hdl/cfws_chk.sv
`default_nettype none

module cfws_chk #(
  parameter int unsigned DEPTH = 1024
) (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire cfws_pkg::out_item_t out_item_i
);

  import cfws_pkg::*;

  localparam logic [OccWidth-1:0] OccFull = OccWidth'(DEPTH);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result beat changed while stalled");

  // one item in flight: ready drops after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  // empty flag agrees with occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.is_empty == (out_item_i.occupancy == '0)))
    else $error("empty flag and occupancy disagree");

  // an empty queue shows no words and no match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.is_empty |->
      out_item_i.front_word == '0 && out_item_i.rear_word == '0 && !out_item_i.match_found)
    else $error("empty queue shows data");

  // a refused push only happens on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_item_i.status == STATUS_FULL) |->
      out_item_i.occupancy == OccFull && out_item_i.popped_word == '0)
    else $error("full status on a queue that is not full");

endmodule

bind circular_fifo_with_search cfws_chk #(
  .DEPTH (DEPTH)
) u_cfws_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_i  (out_item_o)
);

`default_nettype wire
